// ----- sv/vwpc_pkg.sv -----
package vwpc_pkg;

    localparam int TEMP_BITS_DEF = 12;
    localparam int TIME_BITS_DEF = 32;

    localparam int OP_W       = 2;
    localparam int WCODE_W    = 10;
    localparam int PCT_W      = 7;
    localparam int POS_W      = 7;
    localparam int MOVE_W     = 15;
    localparam int FRAC_BITS  = 8;
    localparam int INTERVAL_W = 16;
    localparam int IN_FIXED_W = OP_W + 1 + WCODE_W + 1 + PCT_W;
    localparam int OUT_W      = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_MANUAL = 2'd1;
    localparam logic [OP_W-1:0] OP_APPLY  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLOSE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_TEMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINISH_TEMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPS_KNOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSITIONS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 3'd5;

    localparam logic [WCODE_W-1:0] DRY_CODE   = 10'd701;
    localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
    localparam logic [MOVE_W-1:0]  FULL_Q8    = 15'd25600;

    // snap to actuator step: (p * t + 50) / 100 via reciprocal multiply
    localparam int                 PROD_W     = 14;
    localparam logic [PROD_W-1:0]  ROUND_HALF = 14'd50;
    localparam int                 KPROD_W    = 27;
    localparam logic [12:0]        K_RECIP    = 13'd5243;
    localparam int                 K_SHIFT    = 19;

    localparam int APPLY_DVD_W = 22;

    typedef enum logic [1:0] {
        PATH_NONE,
        PATH_APPLY,
        PATH_DIV
    } path_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic auto_start;
        logic auto_set;
        logic apply_mul;
        logic apply_k;
        logic apply_start;
        logic apply_fin;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        path_t path;
        logic  apply_ok;
        logic  div_done;
    } sts_t;

endpackage

// ----- sv/vent_window_position_control_unit.sv -----
// Vent window position control unit.
// Input stream (s_t*): one event per transaction, tdata carries op, uptime,
// soil temperature and its known flag, weather code and its known flag and
// the manual percent. Output stream (m_t*): exactly one result per event,
// tdata carries the move (valid, direction, amount in Q8 percent), target,
// target known flag and actual opening.
// Configuration registers are written through wr_en/wr_index/wr_data; the
// user must write them only while no event is in flight, as the block does
// not enforce it; writes take effect at once. Events are taken one at a time.
// Manual set, full close and events with no apply step go from capture
// through evaluation to the output; an apply checked but not needed adds the
// check, and one that runs adds the check, the two multiplies and one pass
// of the shared restoring divider (22 steps at default widths, one quotient
// bit per cycle). An auto tick inside the temperature band divides first;
// s_tready returns as m_tvalid rises. The result sits in an output register,
// so a stalled receiver holds only the finished result; the next event is
// accepted and processed, and waits at its end until the register is free.
// Reset clears configuration and all tracked state: target and actual
// unknown, never adjusted, no apply pending, output empty.
module vent_window_position_control_unit #(
    parameter  int TEMP_BITS  = vwpc_pkg::TEMP_BITS_DEF,
    parameter  int TIME_BITS  = vwpc_pkg::TIME_BITS_DEF,
    localparam int IN_W       = TIME_BITS + TEMP_BITS + vwpc_pkg::IN_FIXED_W,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [vwpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [vwpc_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // op, uptime_sec, soil_temp, soil_temp_known, weather_code,
    // weather_known, manual_percent, zero fill
    input  logic [IN_TDATA_W-1:0]           s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // move_valid, move_open, move_amount, target_percent, target_known,
    // actual_percent
    output logic [vwpc_pkg::OUT_W-1:0]      m_tdata
);

    vwpc_pkg::cmd_t cmd;
    vwpc_pkg::sts_t sts;

    vwpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    vwpc_dp #(
        .TEMP_BITS (TEMP_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_data  (s_tdata[IN_W-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule

// ----- sv/vwpc_div.sv -----
module vwpc_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dvd,
    input  logic [DVS_W-1:0] dvs,
    output logic             done,
    output logic [DVD_W-1:0] quo
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dvd;
            dvs_reg <= dvs;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- sv/vwpc_dp.sv -----
module vwpc_dp #(
    parameter  int TEMP_BITS = vwpc_pkg::TEMP_BITS_DEF,
    parameter  int TIME_BITS = vwpc_pkg::TIME_BITS_DEF,
    localparam int IN_W      = TIME_BITS + TEMP_BITS + vwpc_pkg::IN_FIXED_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [vwpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [vwpc_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic [IN_W-1:0]                 in_data,
    input  vwpc_pkg::cmd_t                  cmd,
    output vwpc_pkg::sts_t                  sts,
    output logic [vwpc_pkg::OUT_W-1:0]      out_data
);

    localparam int PCT_W      = vwpc_pkg::PCT_W;
    localparam int MOVE_W     = vwpc_pkg::MOVE_W;
    localparam int FRAC_BITS  = vwpc_pkg::FRAC_BITS;
    localparam int OFS_UP     = vwpc_pkg::OP_W;
    localparam int OFS_SOIL   = OFS_UP + TIME_BITS;
    localparam int OFS_SK     = OFS_SOIL + TEMP_BITS;
    localparam int OFS_WC     = OFS_SK + 1;
    localparam int OFS_WK     = OFS_WC + vwpc_pkg::WCODE_W;
    localparam int OFS_MAN    = OFS_WK + 1;
    localparam int AUTO_DVD_W = TEMP_BITS + PCT_W;
    localparam int DVD_W      = (AUTO_DVD_W > vwpc_pkg::APPLY_DVD_W) ?
                                AUTO_DVD_W : vwpc_pkg::APPLY_DVD_W;
    localparam int DVS_W      = TEMP_BITS;

    // configuration
    logic                              auto_en_reg;
    logic signed [TEMP_BITS-1:0]       start_reg;
    logic signed [TEMP_BITS-1:0]       finish_reg;
    logic                              tknown_reg;
    logic [vwpc_pkg::POS_W-1:0]        pos_reg;
    logic [vwpc_pkg::INTERVAL_W-1:0]   interval_reg;

    // captured transaction
    logic [vwpc_pkg::OP_W-1:0]         op_reg;
    logic [TIME_BITS-1:0]              now_reg;
    logic signed [TEMP_BITS-1:0]       soil_reg;
    logic                              sk_reg;
    logic [vwpc_pkg::WCODE_W-1:0]      wc_reg;
    logic                              wk_reg;
    logic [PCT_W-1:0]                  man_reg;

    // control state
    logic [PCT_W-1:0]     tpct_reg, tpct_next;
    logic                 tv_reg, tv_next;
    logic [PCT_W-1:0]     apct_reg, apct_next;
    logic                 av_reg, av_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic                 lav_reg, lav_next;
    logic                 pend_reg, pend_next;
    logic                 mv_valid_reg, mv_valid_next;
    logic                 mv_open_reg, mv_open_next;
    logic [MOVE_W-1:0]    mv_amount_reg, mv_amount_next;

    logic [vwpc_pkg::PROD_W-1:0]  prod_reg;
    logic [vwpc_pkg::POS_W-1:0]   k_reg;
    logic [vwpc_pkg::OUT_W-1:0]   out_reg;

    logic                         rain;
    logic [TIME_BITS-1:0]         since;
    logic                         rate_ok;
    logic                         auto_go;
    logic                         in_range;
    logic                         above;
    logic signed [TEMP_BITS:0]    offs_full;
    logic signed [TEMP_BITS:0]    span_full;
    logic [AUTO_DVD_W-1:0]        auto_num;
    logic [vwpc_pkg::APPLY_DVD_W-1:0] apply_num;
    logic [vwpc_pkg::KPROD_W-1:0] kprod;
    logic                         div_start;
    logic [DVD_W-1:0]             dvd_in;
    logic [DVS_W-1:0]             dvs_in;
    logic                         div_done;
    logic [DVD_W-1:0]             quo;
    logic [MOVE_W-1:0]            rq;
    logic [MOVE_W-1:0]            aq;
    logic [PCT_W-1:0]             act_new;
    logic [PCT_W-1:0]             man_sat;
    vwpc_pkg::path_t              path;

    assign rain     = wk_reg && (wc_reg < vwpc_pkg::DRY_CODE);
    assign since    = now_reg - last_reg;
    assign rate_ok  = (interval_reg == '0) || !lav_reg ||
                      (!since[TIME_BITS-1] && (since > TIME_BITS'(interval_reg)));
    assign auto_go  = auto_en_reg && rate_ok && sk_reg && tknown_reg;
    assign in_range = (soil_reg > start_reg) && (soil_reg < finish_reg);
    assign above    = soil_reg >= finish_reg;

    assign offs_full = (TEMP_BITS + 1)'(soil_reg) - (TEMP_BITS + 1)'(start_reg);
    assign span_full = (TEMP_BITS + 1)'(finish_reg) - (TEMP_BITS + 1)'(start_reg);
    assign auto_num  = AUTO_DVD_W'(offs_full[TEMP_BITS-1:0]) *
                       AUTO_DVD_W'(vwpc_pkg::PCT_FULL);
    assign apply_num = vwpc_pkg::APPLY_DVD_W'(k_reg) *
                       vwpc_pkg::APPLY_DVD_W'(vwpc_pkg::FULL_Q8) +
                       vwpc_pkg::APPLY_DVD_W'(pos_reg >> 1);
    assign kprod     = vwpc_pkg::KPROD_W'(prod_reg) * vwpc_pkg::KPROD_W'(vwpc_pkg::K_RECIP);

    assign div_start = cmd.auto_start || cmd.apply_start;
    assign dvd_in    = cmd.auto_start ? DVD_W'(auto_num) : DVD_W'(apply_num);
    assign dvs_in    = cmd.auto_start ? span_full[TEMP_BITS-1:0] : DVS_W'(pos_reg);

    assign rq      = quo[MOVE_W-1:0];
    assign aq      = {apct_reg, {FRAC_BITS{1'b0}}};
    assign act_new = (rq[MOVE_W-1:FRAC_BITS] > vwpc_pkg::PCT_FULL) ?
                     vwpc_pkg::PCT_FULL : rq[MOVE_W-1:FRAC_BITS];
    assign man_sat = (man_reg > vwpc_pkg::PCT_FULL) ? vwpc_pkg::PCT_FULL : man_reg;

    vwpc_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dvd   (dvd_in),
        .dvs   (dvs_in),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        path = vwpc_pkg::PATH_NONE;
        case (op_reg)
            vwpc_pkg::OP_TICK:
            begin
                if (rain)
                begin
                    if (tv_reg && (tpct_reg != '0))
                    begin
                        path = vwpc_pkg::PATH_APPLY;
                    end
                end
                else if (auto_go)
                begin
                    path = in_range ? vwpc_pkg::PATH_DIV : vwpc_pkg::PATH_APPLY;
                end
            end
            vwpc_pkg::OP_APPLY:
            begin
                if (pend_reg)
                begin
                    path = vwpc_pkg::PATH_APPLY;
                end
            end
            default:
            begin
                path = vwpc_pkg::PATH_NONE;
            end
        endcase
    end

    assign sts.path     = path;
    assign sts.div_done = div_done;
    assign sts.apply_ok = tv_reg && av_reg && (pos_reg != '0) &&
                          ((tpct_reg != apct_reg) || (tpct_reg == '0) ||
                           (tpct_reg == vwpc_pkg::PCT_FULL));

    always_comb
    begin
        tpct_next      = tpct_reg;
        tv_next        = tv_reg;
        apct_next      = apct_reg;
        av_next        = av_reg;
        last_next      = last_reg;
        lav_next       = lav_reg;
        pend_next      = pend_reg;
        mv_valid_next  = mv_valid_reg;
        mv_open_next   = mv_open_reg;
        mv_amount_next = mv_amount_reg;

        if (cmd.capture)
        begin
            mv_valid_next  = 1'b0;
            mv_open_next   = 1'b0;
            mv_amount_next = '0;
        end

        if (cmd.eval)
        begin
            case (op_reg)
                vwpc_pkg::OP_TICK:
                begin
                    if (rain)
                    begin
                        if (tv_reg && (tpct_reg != '0))
                        begin
                            tpct_next = '0;
                        end
                    end
                    else if (auto_go && !in_range)
                    begin
                        tpct_next = above ? vwpc_pkg::PCT_FULL : '0;
                        tv_next   = 1'b1;
                    end
                end
                vwpc_pkg::OP_MANUAL:
                begin
                    if (!tv_reg)
                    begin
                        apct_next = man_sat;
                        av_next   = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b1;
                    end
                    tpct_next = man_sat;
                    tv_next   = 1'b1;
                end
                vwpc_pkg::OP_CLOSE:
                begin
                    tpct_next      = '0;
                    tv_next        = 1'b1;
                    apct_next      = '0;
                    av_next        = 1'b1;
                    mv_valid_next  = 1'b1;
                    mv_open_next   = 1'b0;
                    mv_amount_next = vwpc_pkg::FULL_Q8;
                end
                default:
                begin
                    tv_next = tv_reg;
                end
            endcase
        end

        if (cmd.auto_set)
        begin
            tpct_next = quo[PCT_W-1:0];
            tv_next   = 1'b1;
        end

        if (cmd.apply_fin && (rq != aq))
        begin
            mv_valid_next  = 1'b1;
            mv_open_next   = rq > aq;
            mv_amount_next = (rq > aq) ? (rq - aq) : (aq - rq);
            apct_next      = act_new;
            last_next      = now_reg;
            lav_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_en_reg   <= 1'b0;
            start_reg     <= '0;
            finish_reg    <= '0;
            tknown_reg    <= 1'b0;
            pos_reg       <= '0;
            interval_reg  <= '0;
            tpct_reg      <= '0;
            tv_reg        <= 1'b0;
            apct_reg      <= '0;
            av_reg        <= 1'b0;
            last_reg      <= '0;
            lav_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            mv_valid_reg  <= 1'b0;
            mv_open_reg   <= 1'b0;
            mv_amount_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    vwpc_pkg::REG_AUTO_ENABLE: auto_en_reg  <= wr_data[0];
                    vwpc_pkg::REG_START_TEMP:  start_reg    <= wr_data[TEMP_BITS-1:0];
                    vwpc_pkg::REG_FINISH_TEMP: finish_reg   <= wr_data[TEMP_BITS-1:0];
                    vwpc_pkg::REG_TEMPS_KNOWN: tknown_reg   <= wr_data[0];
                    vwpc_pkg::REG_POSITIONS:   pos_reg      <= wr_data[vwpc_pkg::POS_W-1:0];
                    vwpc_pkg::REG_INTERVAL:    interval_reg <= wr_data;
                    default:                   auto_en_reg  <= auto_en_reg;
                endcase
            end
            tpct_reg      <= tpct_next;
            tv_reg        <= tv_next;
            apct_reg      <= apct_next;
            av_reg        <= av_next;
            last_reg      <= last_next;
            lav_reg       <= lav_next;
            pend_reg      <= pend_next;
            mv_valid_reg  <= mv_valid_next;
            mv_open_reg   <= mv_open_next;
            mv_amount_reg <= mv_amount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_data[vwpc_pkg::OP_W-1:0];
            now_reg  <= in_data[OFS_SOIL-1:OFS_UP];
            soil_reg <= in_data[OFS_SK-1:OFS_SOIL];
            sk_reg   <= in_data[OFS_SK];
            wc_reg   <= in_data[OFS_WK-1:OFS_WC];
            wk_reg   <= in_data[OFS_WK];
            man_reg  <= in_data[IN_W-1:OFS_MAN];
        end
        if (cmd.apply_mul)
        begin
            prod_reg <= vwpc_pkg::PROD_W'(pos_reg) * vwpc_pkg::PROD_W'(tpct_reg) +
                        vwpc_pkg::ROUND_HALF;
        end
        if (cmd.apply_k)
        begin
            k_reg <= kprod[vwpc_pkg::K_SHIFT + vwpc_pkg::POS_W - 1:vwpc_pkg::K_SHIFT];
        end
        if (cmd.load_out)
        begin
            out_reg <= {(av_reg ? apct_reg : {PCT_W{1'b0}}),
                        tv_reg,
                        (tv_reg ? tpct_reg : {PCT_W{1'b0}}),
                        mv_amount_reg,
                        mv_open_reg,
                        mv_valid_reg};
        end
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_target_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        tv_reg |=> tv_reg)
        else $error("target known flag cleared");

    a_pending_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> pend_reg)
        else $error("apply pending flag cleared");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tpct_reg <= vwpc_pkg::PCT_FULL) && (apct_reg <= vwpc_pkg::PCT_FULL))
        else $error("opening out of range");

    a_move_amount: assert property (@(posedge clk) disable iff (!rst_n)
        mv_valid_reg |-> ((mv_amount_reg != '0) && (mv_amount_reg <= vwpc_pkg::FULL_Q8)))
        else $error("move amount out of range");

    a_no_move_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !mv_valid_reg |-> ((mv_amount_reg == '0) && !mv_open_reg))
        else $error("idle move carries data");
`endif

endmodule

// ----- sv/vwpc_ctrl.sv -----
module vwpc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output vwpc_pkg::cmd_t cmd,
    input  vwpc_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_AUTO_WAIT,
        S_CHECK,
        S_MUL,
        S_KMUL,
        S_DIV_START,
        S_APPLY_WAIT,
        S_APPLY_FIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   load;

    assign load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                case (sts.path)
                    vwpc_pkg::PATH_DIV:
                    begin
                        cmd.auto_start = 1'b1;
                        state_next     = S_AUTO_WAIT;
                    end
                    vwpc_pkg::PATH_APPLY:
                    begin
                        state_next = S_CHECK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_AUTO_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.auto_set = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.apply_ok)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                cmd.apply_mul = 1'b1;
                state_next    = S_KMUL;
            end
            S_KMUL:
            begin
                cmd.apply_k = 1'b1;
                state_next  = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.apply_start = 1'b1;
                state_next      = S_APPLY_WAIT;
            end
            S_APPLY_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_APPLY_FIN;
                end
            end
            S_APPLY_FIN:
            begin
                cmd.apply_fin = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule
